// ----- rtl/beeper_to_pcm_resampler_assert.svh -----
// Assertion macros for the beeper to PCM resampler.
`ifndef BEEPER_TO_PCM_RESAMPLER_ASSERT_SVH
`define BEEPER_TO_PCM_RESAMPLER_ASSERT_SVH

`ifndef ASSERT_OFF
`define BTP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("btp assertion failed");
`define BTP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("btp assertion failed");
`else
`define BTP_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define BTP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/btp_pkg.sv -----
package btp_pkg;

  localparam int TSTATE_W = 17;
  localparam int TPS_W = 12;
  localparam int SPF_W = 11;
  localparam int TPF_W = 17;
  localparam int WIDX_W = 11;
  localparam int SIDX_W = 10;
  localparam int PCM_W = 16;
  localparam int CFG_W = 17;
  localparam int CFG_IDX_W = 2;

  localparam int TIME_BITS_DEF = 17;
  localparam int MAX_SAMPLES = 1024;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [TPS_W-1:0] TPS_RESET = 12'd79;
  localparam logic [SPF_W-1:0] SPF_RESET = 11'd882;
  localparam logic [TPF_W-1:0] TPF_RESET = 17'd69888;

  localparam logic [PCM_W-1:0] SCALE_MAX = 16'hFFFF;
  localparam logic [PCM_W-1:0] PCM_OFFSET = 16'h8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TPS = 2'd0,
    CFG_SPF = 2'd1,
    CFG_TPF = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic               sample;
    logic               fend;
    logic               full_scale;
    logic [TPS_W-1:0]   on_low;
    logic [TPS_W-1:0]   tps;
    logic [SIDX_W-1:0]  index;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_HOLD
  } back_state_t;

endpackage

// ----- rtl/btp_front.sv -----
module btp_front #(
  parameter int TIME_BITS = btp_pkg::TIME_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [btp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [btp_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                push,
  input  logic [btp_pkg::TSTATE_W-1:0]        tstate,
  input  logic                                speaker,
  input  btp_pkg::q_status_t                  q_status,
  output btp_pkg::job_t                       job,
  output logic                                job_push
);

  localparam int AW = (TIME_BITS > btp_pkg::TSTATE_W) ? TIME_BITS : btp_pkg::TSTATE_W;
  localparam logic [AW:0] TIME_MAX = {{(AW + 1 - TIME_BITS){1'b0}}, {TIME_BITS{1'b1}}};

  function automatic logic [AW:0] sat_time(input logic [AW:0] x);
    return (x > TIME_MAX) ? TIME_MAX : x;
  endfunction

  logic [btp_pkg::TPS_W-1:0]    tps_reg;
  logic [btp_pkg::SPF_W-1:0]    spf_reg;
  logic [btp_pkg::TPF_W-1:0]    tpf_reg;
  logic [btp_pkg::TSTATE_W-1:0] last_time;
  logic [TIME_BITS-1:0]         period_elapsed;
  logic [TIME_BITS-1:0]         on_time;
  logic [btp_pkg::WIDX_W-1:0]   write_index;

  logic [btp_pkg::TSTATE_W-1:0] last_time_next;
  logic [TIME_BITS-1:0]         period_elapsed_next;
  logic [TIME_BITS-1:0]         on_time_next;
  logic [btp_pkg::WIDX_W-1:0]   write_index_next;

  logic                         accept;
  logic [btp_pkg::TPS_W-1:0]    tps;
  logic [btp_pkg::SPF_W-1:0]    spf;
  logic                         active;
  logic [btp_pkg::TSTATE_W-1:0] dt;
  logic [AW:0]                  pe_w;
  logic [AW:0]                  on_w;
  logic [AW:0]                  dt_w;
  logic [AW:0]                  tps_w;
  logic [AW:0]                  total;
  logic [AW:0]                  rest;
  logic [AW:0]                  on_pre;
  logic                         fire;
  logic                         pe_lt;
  logic                         fend;

  assign accept = push && !q_status.full;

  always_comb begin
    tps = (tps_reg == '0) ? btp_pkg::TPS_W'(1) : tps_reg;
    spf = (spf_reg > btp_pkg::SPF_W'(btp_pkg::MAX_SAMPLES)) ?
          btp_pkg::SPF_W'(btp_pkg::MAX_SAMPLES) : spf_reg;
    active = write_index < spf;
    dt = (tstate >= last_time) ? tstate - last_time : '0;
    pe_w = (AW + 1)'(period_elapsed);
    on_w = (AW + 1)'(on_time);
    dt_w = (AW + 1)'(dt);
    tps_w = (AW + 1)'(tps);
    total = pe_w + dt_w;
    rest = total - tps_w;
    fire = active && (total > tps_w);
    pe_lt = pe_w < tps_w;
    on_pre = (speaker && pe_lt) ? sat_time(on_w + (tps_w - pe_w)) : on_w;
    fend = (tstate >= tpf_reg);
  end

  always_comb begin
    on_time_next = on_time;
    period_elapsed_next = period_elapsed;
    if (fire) begin
      on_time_next = speaker ? TIME_BITS'(sat_time(rest)) : '0;
      period_elapsed_next = TIME_BITS'(sat_time(rest));
    end else if (active) begin
      on_time_next = speaker ? TIME_BITS'(sat_time(on_w + dt_w)) : on_time;
      period_elapsed_next = TIME_BITS'(sat_time(total));
    end
    last_time_next = fend ? tstate - tpf_reg : tstate;
    if (fend) begin
      write_index_next = '0;
    end else if (fire) begin
      write_index_next = write_index + btp_pkg::WIDX_W'(1);
    end else begin
      write_index_next = write_index;
    end
  end

  always_comb begin
    job.sample = fire;
    job.fend = fend;
    job.full_scale = on_pre >= tps_w;
    job.on_low = on_pre[btp_pkg::TPS_W-1:0];
    job.tps = tps;
    job.index = write_index[btp_pkg::SIDX_W-1:0];
    job_push = accept && (fire || fend);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tps_reg <= btp_pkg::TPS_RESET;
      spf_reg <= btp_pkg::SPF_RESET;
      tpf_reg <= btp_pkg::TPF_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        btp_pkg::CFG_TPS: tps_reg <= cfg_data[btp_pkg::TPS_W-1:0];
        btp_pkg::CFG_SPF: spf_reg <= cfg_data[btp_pkg::SPF_W-1:0];
        btp_pkg::CFG_TPF: tpf_reg <= cfg_data[btp_pkg::TPF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_time <= '0;
      period_elapsed <= '0;
      on_time <= '0;
      write_index <= '0;
    end else if (accept) begin
      last_time <= last_time_next;
      period_elapsed <= period_elapsed_next;
      on_time <= on_time_next;
      write_index <= write_index_next;
    end
  end

endmodule

// ----- rtl/btp_fifo.sv -----
module btp_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  btp_pkg::job_t       din,
  input  logic                pop,
  output btp_pkg::job_t       dout,
  output btp_pkg::q_status_t  status
);

  localparam int DEPTH = btp_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  btp_pkg::job_t     entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign status.full = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);
  assign do_push = push && !status.full;
  assign do_pop = pop && !status.empty;
  assign dout = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/btp_back.sv -----
module btp_back (
  input  logic                               clk,
  input  logic                               rst,
  input  btp_pkg::q_status_t                 q_status,
  input  btp_pkg::job_t                      job_in,
  output logic                               q_pop,
  output logic                               empty,
  input  logic                               pop,
  output logic                               sample_valid,
  output logic signed [btp_pkg::PCM_W-1:0]   sample_value,
  output logic [btp_pkg::SIDX_W-1:0]         sample_index,
  output logic                               frame_end
);

  localparam int QW = btp_pkg::PCM_W;
  localparam int RW = btp_pkg::TPS_W;
  localparam int NW = RW + QW;
  localparam int CW = $clog2(QW);

  btp_pkg::back_state_t state;
  btp_pkg::back_state_t state_next;

  btp_pkg::job_t   job;
  logic [RW-1:0]   rem;
  logic [QW-1:0]   num;
  logic [QW-1:0]   quot;
  logic [CW-1:0]   cnt;
  logic [NW-1:0]   dividend;
  logic [RW:0]     trial;
  logic            ge;

  always_comb begin
    state_next = state;
    unique case (state)
      btp_pkg::BK_IDLE: begin
        if (!q_status.empty) begin
          state_next = (job_in.sample && !job_in.full_scale) ?
                       btp_pkg::BK_DIV : btp_pkg::BK_HOLD;
        end
      end
      btp_pkg::BK_DIV: begin
        if (cnt == CW'(QW - 1)) begin
          state_next = btp_pkg::BK_HOLD;
        end
      end
      btp_pkg::BK_HOLD: begin
        if (pop) begin
          state_next = btp_pkg::BK_IDLE;
        end
      end
      default: state_next = btp_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (state == btp_pkg::BK_IDLE) && !q_status.empty;
    empty = (state != btp_pkg::BK_HOLD);
  end

  always_comb begin
    dividend = {job_in.on_low, {QW{1'b0}}} - NW'(job_in.on_low);
    trial = {rem, num[QW-1]};
    ge = trial >= {1'b0, job.tps};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= btp_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job <= job_in;
      rem <= dividend[NW-1:QW];
      num <= dividend[QW-1:0];
      quot <= job_in.full_scale ? btp_pkg::SCALE_MAX : '0;
      cnt <= '0;
    end else if (state == btp_pkg::BK_DIV) begin
      rem <= ge ? RW'(trial - {1'b0, job.tps}) : trial[RW-1:0];
      num <= {num[QW-2:0], 1'b0};
      quot <= {quot[QW-2:0], ge};
      cnt <= cnt + CW'(1);
    end
  end

  always_comb begin
    sample_valid = job.sample;
    sample_value = job.sample ? signed'(quot ^ btp_pkg::PCM_OFFSET) : '0;
    sample_index = job.sample ? job.index : '0;
    frame_end = job.fend;
  end

endmodule

// ----- rtl/beeper_to_pcm_resampler.sv -----
// Beeper to PCM resampler: turns time-stamped 1-bit speaker events into
// signed 16-bit PCM samples by box-filtering the speaker on-time.
// Input channel: drive tstate and speaker with push; the event transfers
// when push is high and full is low. Events that complete no sample and
// end no frame are absorbed and give no result.
// Result channel: while empty is low the oldest result is on sample_valid,
// sample_value, sample_index and frame_end; it transfers when pop is high.
// Configuration: write cfg_data to register cfg_index with cfg_write, only
// while the block holds no pending work.
// Flow: an event that completes a sample or ends a frame queues one result;
// the back end pops it and holds it until pop. A sample that is not full
// scale first passes the restoring divider, one quotient bit per cycle. The
// back end takes no new job from the queue until its result is popped.
// A two-entry queue sits between the event front end and the divider.
// Reset restores the register defaults, clears the accumulators and empties
// the queue and the back end. When the receiver stalls, the result holds,
// the queue fills and full rises until pop frees space.
`include "beeper_to_pcm_resampler_assert.svh"

module beeper_to_pcm_resampler #(
  parameter int TIME_BITS = btp_pkg::TIME_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [btp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [btp_pkg::CFG_W-1:0]          cfg_data,
  input  logic                               push,
  output logic                               full,
  input  logic [btp_pkg::TSTATE_W-1:0]       tstate,
  input  logic                               speaker,
  output logic                               empty,
  input  logic                               pop,
  output logic                               sample_valid,
  output logic signed [btp_pkg::PCM_W-1:0]   sample_value,
  output logic [btp_pkg::SIDX_W-1:0]         sample_index,
  output logic                               frame_end
);

  btp_pkg::job_t      front_job;
  btp_pkg::job_t      back_job;
  btp_pkg::q_status_t q_status;
  logic               job_push;
  logic               q_pop;

  assign full = q_status.full;

  btp_front #(
    .TIME_BITS(TIME_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .push(push),
    .tstate(tstate),
    .speaker(speaker),
    .q_status(q_status),
    .job(front_job),
    .job_push(job_push)
  );

  btp_fifo u_fifo (
    .clk(clk),
    .rst(rst),
    .push(job_push),
    .din(front_job),
    .pop(q_pop),
    .dout(back_job),
    .status(q_status)
  );

  btp_back u_back (
    .clk(clk),
    .rst(rst),
    .q_status(q_status),
    .job_in(back_job),
    .q_pop(q_pop),
    .empty(empty),
    .pop(pop),
    .sample_valid(sample_valid),
    .sample_value(sample_value),
    .sample_index(sample_index),
    .frame_end(frame_end)
  );

  `BTP_ASSERT_IMPLY(a_result_not_blank, clk, rst, !empty, sample_valid || frame_end)
  `BTP_ASSERT_IMPLY(a_frame_only_zero, clk, rst, !empty && !sample_valid,
                    sample_value == '0 && sample_index == '0)
  `BTP_ASSERT_NEXT(a_full_holds, clk, rst, q_status.full && !q_pop, q_status.full)

endmodule

// ----- tb/tb_top.sv -----
module tb_top;

  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 40;
  localparam int TARGET_EVENTS = 1650;
  localparam logic [63:0] TICK_MAX = 64'd131071;

  typedef struct packed {
    logic        valid;
    logic [15:0] value;
    logic [9:0]  index;
    logic        fend;
  } pcm_result_t;

  typedef enum logic {PLAN_EVENT, PLAN_RATES} plan_kind_t;

  typedef struct packed {
    plan_kind_t  kind;
    logic [16:0] tstate;
    logic        speaker;
    logic [11:0] tps;
    logic [10:0] spf;
    logic [16:0] tpf;
    logic        typed;
    pcm_result_t res;
  } plan_row_t;

  localparam int NUM_PLAN = 27;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = btp_pkg::CFG_TPS;
  logic [16:0] cfg_data = '0;
  logic        push = 1'b0;
  logic        full;
  logic [16:0] tstate = '0;
  logic        speaker = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic        sample_valid;
  logic signed [15:0] sample_value;
  logic [9:0]  sample_index;
  logic        frame_end;

  beeper_to_pcm_resampler u_top (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .full(full), .tstate(tstate), .speaker(speaker),
    .empty(empty), .pop(pop),
    .sample_valid(sample_valid), .sample_value(sample_value),
    .sample_index(sample_index), .frame_end(frame_end)
  );

  // Directed part: rows with a typed result are checked against that result.
  plan_row_t plan [NUM_PLAN] = '{
    '{PLAN_EVENT, 17'd0, 1'b0, 12'd0, 11'd0, 17'd0, 1'b0, '0},
    '{PLAN_EVENT, 17'd80, 1'b1, 12'd0, 11'd0, 17'd0, 1'b1, {1'b1, 16'h7FFF, 10'd0, 1'b0}},
    '{PLAN_EVENT, 17'd160, 1'b0, 12'd0, 11'd0, 17'd0, 1'b0, '0},
    '{PLAN_EVENT, 17'd100, 1'b1, 12'd0, 11'd0, 17'd0, 1'b0, '0},
    '{PLAN_EVENT, 17'd69888, 1'b1, 12'd0, 11'd0, 17'd0, 1'b0, '0},
    '{PLAN_EVENT, 17'd0, 1'b1, 12'd0, 11'd0, 17'd0, 1'b1, {1'b1, 16'h7FFF, 10'd0, 1'b0}},
    '{PLAN_RATES, 17'd0, 1'b0, 12'd0, 11'd2047, 17'd0, 1'b0, '0},
    '{PLAN_EVENT, 17'd5, 1'b1, 12'd0, 11'd0, 17'd0, 1'b1, {1'b1, 16'h7FFF, 10'd1, 1'b1}},
    '{PLAN_EVENT, 17'd131071, 1'b0, 12'd0, 11'd0, 17'd0, 1'b0, '0},
    '{PLAN_EVENT, 17'd131071, 1'b1, 12'd0, 11'd0, 17'd0, 1'b0, '0},
    '{PLAN_RATES, 17'd0, 1'b0, 12'd4095, 11'd1, 17'd131071, 1'b0, '0},
    '{PLAN_EVENT, 17'd0, 1'b0, 12'd0, 11'd0, 17'd0, 1'b0, '0},
    '{PLAN_EVENT, 17'd4096, 1'b1, 12'd0, 11'd0, 17'd0, 1'b0, '0},
    '{PLAN_EVENT, 17'd8000, 1'b1, 12'd0, 11'd0, 17'd0, 1'b0, '0},
    '{PLAN_EVENT, 17'd131071, 1'b1, 12'd0, 11'd0, 17'd0, 1'b0, '0},
    '{PLAN_EVENT, 17'd4095, 1'b0, 12'd0, 11'd0, 17'd0, 1'b0, '0},
    '{PLAN_EVENT, 17'd8191, 1'b1, 12'd0, 11'd0, 17'd0, 1'b0, '0},
    '{PLAN_RATES, 17'd0, 1'b0, 12'd1, 11'd0, 17'd100, 1'b0, '0},
    '{PLAN_EVENT, 17'd50, 1'b1, 12'd0, 11'd0, 17'd0, 1'b0, '0},
    '{PLAN_EVENT, 17'd100, 1'b1, 12'd0, 11'd0, 17'd0, 1'b1, {1'b0, 16'h0000, 10'd0, 1'b1}},
    '{PLAN_RATES, 17'd0, 1'b0, 12'd79, 11'd882, 17'd69888, 1'b0, '0},
    '{PLAN_EVENT, 17'd0, 1'b1, 12'd0, 11'd0, 17'd0, 1'b0, '0},
    '{PLAN_EVENT, 17'd40, 1'b0, 12'd0, 11'd0, 17'd0, 1'b0, '0},
    '{PLAN_EVENT, 17'd79, 1'b1, 12'd0, 11'd0, 17'd0, 1'b0, '0},
    '{PLAN_EVENT, 17'd200, 1'b1, 12'd0, 11'd0, 17'd0, 1'b0, '0},
    '{PLAN_EVENT, 17'd69887, 1'b0, 12'd0, 11'd0, 17'd0, 1'b0, '0},
    '{PLAN_EVENT, 17'd69888, 1'b1, 12'd0, 11'd0, 17'd0, 1'b0, '0}
  };

  logic [11:0] tps_cfg = 12'd79;
  logic [10:0] spf_cfg = 11'd882;
  logic [16:0] tpf_cfg = 17'd69888;
  logic [63:0] prev_stamp = '0;
  logic [63:0] period_ticks = '0;
  logic [63:0] on_ticks = '0;
  logic [10:0] slot = '0;

  pcm_result_t pending_samples[$];
  pcm_result_t want;
  int  n_bad = 0;
  int  n_live = 0;
  int  idle_cnt = 0;
  bit  no_gaps = 1'b0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic logic [63:0] sat_ticks(input logic [63:0] x);
    return (x > TICK_MAX) ? TICK_MAX : x;
  endfunction

  function automatic logic [63:0] sample_period();
    return (tps_cfg == 0) ? 64'd1 : 64'(tps_cfg);
  endfunction

  // Box-filter one speaker event; returns 1 when it yields a result.
  function automatic bit decimate_event(input logic [16:0] t, input logic spk,
                                        output pcm_result_t r);
    logic [63:0] per;
    logic [63:0] lim;
    logic [63:0] dt;
    logic [63:0] total;
    logic [63:0] scaled;
    per = sample_period();
    lim = (spf_cfg > 11'd1024) ? 64'd1024 : 64'(spf_cfg);
    r = '0;
    if (64'(slot) < lim) begin
      dt = (64'(t) >= prev_stamp) ? 64'(t) - prev_stamp : 64'd0;
      total = period_ticks + dt;
      if (total > per) begin
        if (spk && period_ticks < per) on_ticks = sat_ticks(on_ticks + per - period_ticks);
        scaled = (on_ticks * 64'd65535) / per;
        if (scaled > 64'd65535) scaled = 64'd65535;
        r.valid = 1'b1;
        r.value = scaled[15:0] ^ 16'h8000;
        r.index = slot[9:0];
        slot = slot + 11'd1;
        dt = total - per;
        on_ticks = '0;
        period_ticks = '0;
      end
      if (spk) on_ticks = sat_ticks(on_ticks + dt);
      period_ticks = sat_ticks(period_ticks + dt);
    end
    prev_stamp = 64'(t);
    if (t >= tpf_cfg) begin
      slot = '0;
      prev_stamp = 64'(t) - 64'(tpf_cfg);
      r.fend = 1'b1;
    end
    return r.valid || r.fend;
  endfunction

  task automatic send_event(input logic [16:0] t, input logic spk,
                            input logic typed, input pcm_result_t fixed);
    pcm_result_t r;
    bit hit;
    while (!no_gaps && $urandom_range(99) < 14) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    tstate <= t;
    speaker <= spk;
    do @(posedge clk); while (full);
    hit = decimate_event(t, spk, r);
    if (typed) pending_samples.push_back(fixed);
    else if (hit) pending_samples.push_back(r);
    n_live++;
  endtask

  task automatic settle();
    push <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_rates(input logic [11:0] p, input logic [10:0] s, input logic [16:0] f);
    cfg_write <= 1'b1;
    cfg_index <= btp_pkg::CFG_TPS;
    cfg_data <= 17'(p);
    @(posedge clk);
    cfg_index <= btp_pkg::CFG_SPF;
    cfg_data <= 17'(s);
    @(posedge clk);
    cfg_index <= btp_pkg::CFG_TPF;
    cfg_data <= f;
    @(posedge clk);
    cfg_write <= 1'b0;
    tps_cfg = p;
    spf_cfg = s;
    tpf_cfg = f;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_samples.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("unexpected transfer: valid=%0b value=%h index=%0d frame_end=%0b",
                     sample_valid, sample_value, sample_index, frame_end);
        end else begin
          want = pending_samples.pop_front();
          if (sample_valid !== want.valid || sample_value !== want.value ||
              sample_index !== want.index || frame_end !== want.fend) begin
            n_bad++;
            if (n_bad <= 10)
              $display({"mismatch: expected valid=%0b value=%h index=%0d frame_end=%0b, ",
                        "got valid=%0b value=%h index=%0d frame_end=%0b"},
                       want.valid, want.value, want.index, want.fend,
                       sample_valid, sample_value, sample_index, frame_end);
          end
        end
      end
      pop <= no_gaps || ($urandom_range(99) >= 14);
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
  end

  initial begin
    while (idle_cnt < STALL_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [11:0] p;
    logic [10:0] s;
    logic [16:0] f;
    logic [63:0] per;
    logic [63:0] nxt;
    logic [16:0] t;
    int n_items;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == PLAN_RATES) begin
        settle();
        set_rates(plan[i].tps, plan[i].spf, plan[i].tpf);
      end else begin
        send_event(plan[i].tstate, plan[i].speaker, plan[i].typed, plan[i].res);
      end
    end

    while (n_live < TARGET_EVENTS) begin
      case ($urandom_range(9))
        0: p = 12'd0;
        1: p = 12'd4095;
        2: p = 12'($urandom_range(0, 4095));
        default: p = 12'($urandom_range(1, 100));
      endcase
      case ($urandom_range(9))
        0: s = 11'd0;
        1: s = 11'($urandom_range(1024, 2047));
        2: s = 11'($urandom_range(0, 2047));
        default: s = 11'($urandom_range(1, 24));
      endcase
      case ($urandom_range(9))
        0: f = 17'd0;
        1: f = 17'd131071;
        2: f = 17'($urandom_range(0, 131071));
        default: f = 17'($urandom_range(100, 6000));
      endcase
      settle();
      set_rates(p, s, f);
      n_items = $urandom_range(20, 80);
      repeat (n_items) begin
        no_gaps = (n_live >= 500 && n_live < 800);
        per = sample_period();
        case ($urandom_range(99)) inside
          [0:7]: nxt = 64'($urandom_range(0, 131071));
          [8:11]: nxt = (prev_stamp > 64'd0) ?
                        prev_stamp - 64'($urandom_range(1, 32'(prev_stamp))) : 64'd0;
          [12:19]: nxt = prev_stamp + 64'($urandom_range(0, 20000));
          default: nxt = prev_stamp + 64'($urandom_range(0, 32'(2 * per + 2)));
        endcase
        t = (nxt > TICK_MAX) ? 17'd131071 : nxt[16:0];
        send_event(t, 1'($urandom_range(1)), 1'b0, '0);
      end
    end

    push <= 1'b0;
    no_gaps = 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (n_bad == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/btp_pkg.sv
rtl/btp_front.sv
rtl/btp_fifo.sv
rtl/btp_back.sv
rtl/beeper_to_pcm_resampler.sv
tb/tb_top.sv
